// File: hdl/afs_pkg.sv
// Shared types, constants and the sample-rate table of the ADTS frame synchronizer.
`timescale 1ns / 1ps

package afs_pkg;

  localparam int HdrBytes = 6;
  localparam int QueueDepth = 2;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] SYNC_MASK = 8'hF6;
  localparam logic [7:0] SYNC_VALUE = 8'hF0;
  localparam logic [12:0] MAX_LEN_RESET = 13'd6144;

  typedef enum logic {
    KIND_BYTE,
    KIND_HEADER
  } kind_e;

  // One queue entry: either a single pass-through byte or a whole accepted header.
  typedef struct packed {
    kind_e            kind;
    logic [5:0][7:0]  data;
    logic [3:0]       rate_index;
    logic [2:0]       channels;
    logic [12:0]      length;
    logic             frame_end;
    logic             truncated;
  } entry_t;

  function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
    logic [16:0] rate;
    case (idx)
      4'd0:    rate = 17'd96000;
      4'd1:    rate = 17'd88200;
      4'd2:    rate = 17'd64000;
      4'd3:    rate = 17'd48000;
      4'd4:    rate = 17'd44100;
      4'd5:    rate = 17'd32000;
      4'd6:    rate = 17'd24000;
      4'd7:    rate = 17'd22050;
      4'd8:    rate = 17'd16000;
      4'd9:    rate = 17'd12000;
      4'd10:   rate = 17'd11025;
      4'd11:   rate = 17'd8000;
      4'd12:   rate = 17'd7350;
      default: rate = 17'd0;
    endcase
    return rate;
  endfunction

endpackage

// File: hdl/afs_front.sv
// Front part: header window, sync search, frame byte counting and queue entry formation.
`timescale 1ns / 1ps

module afs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_eos_i,
  input  logic                 cfg_we_i,
  input  logic [12:0]          cfg_wdata_i,
  input  logic                 full_i,
  output logic                 push_o,
  output afs_pkg::entry_t      entry_o
);

  localparam logic [2:0] FillFull = 3'(afs_pkg::HdrBytes);
  localparam logic [12:0] LenMin = 13'(afs_pkg::HdrBytes);

  logic [5:0][7:0] win_q, win_d, win_next;
  logic [2:0]      fill_q, fill_d, fill_next;
  logic [12:0]     rem_q, rem_d, rem_dec, rem_hdr;
  logic [3:0]      rate_q, rate_d, hdr_rate;
  logic [2:0]      chan_q, chan_d, hdr_chan;
  logic [12:0]     len_q, len_d, hdr_len;
  logic [12:0]     max_q;
  logic            accept, in_frame, is_hdr, len_ok, take_hdr;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_frame   = (rem_q != 13'd0);

  always_comb begin
    win_next  = win_q;
    fill_next = fill_q;
    if (fill_q < FillFull) begin
      win_next[fill_q] = in_byte_i;
      fill_next        = 3'(fill_q + 3'd1);
    end else begin
      for (int i = 0; i < afs_pkg::HdrBytes - 1; i++) begin
        win_next[i] = win_q[i + 1];
      end
      win_next[afs_pkg::HdrBytes - 1] = in_byte_i;
    end
  end

  assign hdr_len  = {win_next[3][1:0], win_next[4], win_next[5][7:5]};
  assign hdr_rate = win_next[2][5:2];
  assign hdr_chan = {win_next[2][0], win_next[3][7:6]};
  assign is_hdr   = (fill_next == FillFull) && (win_next[0] == afs_pkg::SYNC_BYTE) &&
                    ((win_next[1] & afs_pkg::SYNC_MASK) == afs_pkg::SYNC_VALUE);
  assign len_ok   = (hdr_len >= LenMin) && (hdr_len <= max_q);
  assign take_hdr = !in_frame && is_hdr && len_ok;
  assign rem_dec  = 13'(rem_q - 13'd1);
  assign rem_hdr  = 13'(hdr_len - LenMin);

  always_comb begin
    entry_o = '0;
    if (in_frame) begin
      entry_o.kind       = afs_pkg::KIND_BYTE;
      entry_o.data[0]    = in_byte_i;
      entry_o.rate_index = rate_q;
      entry_o.channels   = chan_q;
      entry_o.length     = len_q;
      entry_o.truncated  = in_eos_i && (rem_dec != 13'd0);
      entry_o.frame_end  = (rem_dec == 13'd0) || entry_o.truncated;
    end else begin
      entry_o.kind       = afs_pkg::KIND_HEADER;
      entry_o.data       = win_next;
      entry_o.rate_index = hdr_rate;
      entry_o.channels   = hdr_chan;
      entry_o.length     = hdr_len;
      entry_o.truncated  = in_eos_i && (rem_hdr != 13'd0);
      entry_o.frame_end  = (rem_hdr == 13'd0) || entry_o.truncated;
    end
  end

  assign push_o = accept && (in_frame || take_hdr);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    rem_d  = rem_q;
    rate_d = rate_q;
    chan_d = chan_q;
    len_d  = len_q;
    if (accept) begin
      if (in_frame) begin
        rem_d = rem_dec;
      end else if (take_hdr) begin
        rem_d  = rem_hdr;
        rate_d = hdr_rate;
        chan_d = hdr_chan;
        len_d  = hdr_len;
        win_d  = '0;
        fill_d = 3'd0;
      end else begin
        win_d  = win_next;
        fill_d = fill_next;
      end
      if (in_eos_i) begin
        win_d  = '0;
        fill_d = 3'd0;
        rem_d  = 13'd0;
        rate_d = 4'd0;
        chan_d = 3'd0;
        len_d  = 13'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= 3'd0;
      rem_q  <= 13'd0;
      rate_q <= 4'd0;
      chan_q <= 3'd0;
      len_q  <= 13'd0;
      max_q  <= afs_pkg::MAX_LEN_RESET;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
      rem_q  <= rem_d;
      rate_q <= rate_d;
      chan_q <= chan_d;
      len_q  <= len_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: hdl/afs_queue.sv
// Short first-in first-out queue of entries between the front and back parts.
`timescale 1ns / 1ps

module afs_queue #(
  parameter int Depth = afs_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  afs_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output afs_pkg::entry_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  afs_pkg::entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : PtrW'(wr_q + 1'b1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : PtrW'(rd_q + 1'b1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= CntW'(cnt_q + 1'b1);
        2'b01:   cnt_q <= CntW'(cnt_q - 1'b1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: hdl/afs_back.sv
// Back part: expands queue entries into tagged result bytes behind an output register.
`timescale 1ns / 1ps

module afs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  afs_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [47:0]     out_data_o,
  output logic [2:0]      out_user_o,
  output logic            out_last_o
);

  localparam logic [2:0] IdxLast = 3'(afs_pkg::HdrBytes - 1);

  logic [2:0]  idx_q;
  logic        valid_q;
  logic [47:0] data_q;
  logic [2:0]  user_q;
  logic        last_q;
  logic        advance, is_hdr, final_byte;
  logic [7:0]  cur_byte;

  assign advance    = !empty_i && (!valid_q || out_ready_i);
  assign is_hdr     = (head_i.kind == afs_pkg::KIND_HEADER);
  assign final_byte = !is_hdr || (idx_q == IdxLast);
  assign cur_byte   = is_hdr ? head_i.data[idx_q] : head_i.data[0];
  assign pop_o      = advance && final_byte;

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_q <= {3'b000, head_i.length, head_i.channels,
                 afs_pkg::rate_lookup(head_i.rate_index), head_i.rate_index, cur_byte};
      // Flags are {last result of the request, truncated, frame start}.
      user_q <= {final_byte, final_byte && head_i.truncated, is_hdr && (idx_q == 3'd0)};
      last_q <= final_byte && head_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      if (advance) begin
        valid_q <= 1'b1;
        idx_q   <= final_byte ? 3'd0 : 3'(idx_q + 3'd1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/adts_frame_synchronizer.sv
// Top level of the ADTS frame synchronizer: front part, entry queue and back part.
`timescale 1ns / 1ps

//  Channel   Direction  tdata                                  tuser / tlast
//  s_axis    in         [7:0] data byte                        tlast: end of stream
//  m_axis    out        byte, rate idx, rate, chans, length    tuser: start, trunc, last
//  cfg       in         [12:0] max_frame_length (write only)   none
//
// The block takes one byte per cycle while the queue has room. A byte inside a frame
// yields one result; a byte that completes an accepted header yields six results,
// which the back part sends while the front part takes bytes until the queue fills.
// The output side sets the sustained rate: one result per cycle if m_axis is ready.
// Reset is asynchronous and active low; it clears the window, the byte counter, the
// queue and the output register, and loads max_frame_length with 6144.
// A stall on m_axis holds the output register, backs up the queue and then drops
// s_axis_tready; bytes that are dropped while hunting still pass through the front part.

module adts_frame_synchronizer #(
  parameter int QueueDepth = afs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [11:8] rate_index, [28:12] sample_rate_hz, [31:29] channel_config,
  // [44:32] length_of_frame, [47:45] zero
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [0] frame_start, [1] truncated, [2] last_result
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i
);

  afs_pkg::entry_t push_entry, head_entry;
  logic            push, pop, full, empty;

  // The front part owns the search window and the configuration register.
  afs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // The queue lets the front part keep hunting while a header is still being sent.
  afs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_entry)
  );

  // The back part walks each entry one byte per ready cycle into the output register.
  afs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: hdl/afs_checker.sv
// Port-level checks of the ADTS frame synchronizer and their binding to the top level.
`timescale 1ns / 1ps

module afs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A truncated byte always closes its frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("truncated result without frame end");

  // A truncated byte is the last result of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[2])
    else $error("truncated result is not the last of its request");

  // Every accepted frame is at least one header long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[44:32] >= 13'd6)
    else $error("frame start with a length below the header size");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

endmodule

bind adts_frame_synchronizer afs_checker u_afs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: dv/tb_adts_frame_synchronizer.sv
// Self-checking testbench for the ADTS frame synchronizer with its own byte-level predictor.
`timescale 1ns / 1ps

module tb_adts_frame_synchronizer;

  // Cycles allowed for bytes still inside the front part and entry queue to settle.
  localparam int SETTLE_CYCLES = 32;
  // Length of the long receiver hold that forces the entry queue to fill.
  localparam int LONG_HOLD = 300;

  // One expected output request, with every field the block tags a frame byte with.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_start;
    logic        frame_end;
    logic        truncated;
    logic [3:0]  rate_index;
    logic [16:0] sample_rate_hz;
    logic [2:0]  channel_config;
    logic [12:0] length_of_frame;
    logic        last_result;
  } adts_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;

  // Sample rate in Hz for each sampling frequency index; the top three are reserved.
  logic [16:0] rate_hz_tab [16] = '{
    17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000, 17'd24000,
    17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000, 17'd7350, 17'd0, 17'd0, 17'd0
  };

  // Predictor state: the hunting window, the frame byte counter and the latched header.
  logic [7:0]  win_bytes [6];
  int unsigned win_fill = 0;
  logic [12:0] remain_cnt = '0;
  logic [3:0]  hold_rate_idx = '0;
  logic [2:0]  hold_chans = '0;
  logic [12:0] hold_len = '0;
  logic [12:0] max_len_cfg = afs_pkg::MAX_LEN_RESET;

  adts_beat_t  pending_beats_q [$];

  // Knobs that shape the traffic on both sides.
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit long_hold_req = 1'b0;
  int unsigned rx_hold_cnt = 0;

  int unsigned mismatch_cnt = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned trunc_seen = 0;
  int unsigned frame_bytes_sent = 0;

  adts_frame_synchronizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The run is cut off here if it hangs; a correct run ends well before this point.
  initial begin
    #2ms;
    $error("run exceeded its time limit");
    $display("*** FAILED ***");
    $finish;
  end

  // Builds one output request from the header fields latched for the current frame.
  function automatic adts_beat_t make_beat(input logic [7:0] b, input logic start,
                                           input logic fin);
    adts_beat_t beat;
    beat.out_byte        = b;
    beat.frame_start     = start;
    beat.frame_end       = fin;
    beat.truncated       = 1'b0;
    beat.rate_index      = hold_rate_idx;
    beat.sample_rate_hz  = rate_hz_tab[hold_rate_idx];
    beat.channel_config  = hold_chans;
    beat.length_of_frame = hold_len;
    beat.last_result     = 1'b0;
    return beat;
  endfunction

  function automatic void clear_sync_state();
    for (int i = 0; i < afs_pkg::HdrBytes; i++) win_bytes[i] = '0;
    win_fill      = 0;
    remain_cnt    = '0;
    hold_rate_idx = '0;
    hold_chans    = '0;
    hold_len      = '0;
  endfunction

  // Works out the output requests caused by one accepted byte and queues them.
  function automatic void predict_sync(input logic [7:0] b, input logic eos);
    adts_beat_t  step_beats [6];
    int          n;
    logic [12:0] len13;
    n = 0;
    if (remain_cnt != 0) begin
      // Inside a frame every byte passes straight through.
      remain_cnt = remain_cnt - 13'd1;
      step_beats[n] = make_beat(b, 1'b0, remain_cnt == 0);
      n++;
    end else begin
      // Hunting: fill the window first, then slide it one byte at a time.
      if (win_fill < afs_pkg::HdrBytes) begin
        win_bytes[win_fill] = b;
        win_fill++;
      end else begin
        for (int i = 0; i < afs_pkg::HdrBytes - 1; i++) win_bytes[i] = win_bytes[i + 1];
        win_bytes[afs_pkg::HdrBytes - 1] = b;
      end
      if (win_fill == afs_pkg::HdrBytes && win_bytes[0] == afs_pkg::SYNC_BYTE &&
          (win_bytes[1] & afs_pkg::SYNC_MASK) == afs_pkg::SYNC_VALUE) begin
        len13 = {win_bytes[3][1:0], win_bytes[4], win_bytes[5][7:5]};
        // Lengths below the header size or above the programmed limit are not frames.
        if (len13 >= afs_pkg::HdrBytes && len13 <= max_len_cfg) begin
          hold_rate_idx = win_bytes[2][5:2];
          hold_chans    = {win_bytes[2][0], win_bytes[3][7:6]};
          hold_len      = len13;
          remain_cnt    = len13 - 13'(afs_pkg::HdrBytes);
          for (int i = 0; i < afs_pkg::HdrBytes; i++) begin
            step_beats[n] = make_beat(win_bytes[i], i == 0,
                                      i == afs_pkg::HdrBytes - 1 && remain_cnt == 0);
            n++;
          end
          for (int i = 0; i < afs_pkg::HdrBytes; i++) win_bytes[i] = '0;
          win_fill = 0;
        end
      end
    end
    // End of stream cuts an unfinished frame on the last byte sent for this step.
    if (eos) begin
      if (remain_cnt != 0 && n > 0) begin
        step_beats[n - 1].frame_end = 1'b1;
        step_beats[n - 1].truncated = 1'b1;
      end
      clear_sync_state();
    end
    if (n > 0) step_beats[n - 1].last_result = 1'b1;
    for (int i = 0; i < n; i++) pending_beats_q.push_back(step_beats[i]);
  endfunction

  // Offers one byte, optionally after a random idle burst, and waits for its handshake.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sync(b, eos);
  endtask

  // Sends a header claiming the given length, followed by random payload bytes.
  // Only the first n_send bytes go out; end of stream marks byte eos_at, and the
  // frame stops there.
  task automatic send_frame(input int unsigned len, input int unsigned n_send,
                            input int unsigned eos_at);
    logic [7:0]  hdr [6];
    logic [7:0]  rnd;
    logic [12:0] len13;
    int unsigned last_idx;
    len13  = len;
    hdr[0] = afs_pkg::SYNC_BYTE;
    rnd    = $urandom_range(0, 255);
    hdr[1] = afs_pkg::SYNC_VALUE | (rnd & ~afs_pkg::SYNC_MASK);
    hdr[2] = $urandom_range(0, 255);
    rnd    = $urandom_range(0, 255);
    hdr[3] = {rnd[7:2], len13[12:11]};
    hdr[4] = len13[10:3];
    rnd    = $urandom_range(0, 255);
    hdr[5] = {len13[2:0], rnd[4:0]};
    last_idx = (eos_at < n_send) ? eos_at : n_send - 1;
    for (int i = 0; i <= last_idx; i++) begin
      rnd = $urandom_range(0, 255);
      send_byte((i < afs_pkg::HdrBytes) ? hdr[i] : rnd, i == eos_at);
    end
    frame_bytes_sent += last_idx + 1;
  endtask

  // Drops the request line and waits until every expected result has come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_beats_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [12:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    max_len_cfg = value;
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, separated by a few noise bytes,
  // with some short headers, over-long headers and streams cut short mixed in.
  task automatic random_stream(input int unsigned target);
    int unsigned goal;
    int unsigned len;
    int unsigned pick;
    int unsigned top;
    int unsigned small_top;
    int unsigned eos_at;
    logic [7:0]  nb;
    goal = frame_bytes_sent + target;
    while (frame_bytes_sent < goal) begin
      repeat ($urandom_range(0, 3)) begin
        nb = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
        send_byte(nb, $urandom_range(0, 49) == 0);
      end
      pick = $urandom_range(0, 99);
      top = (max_len_cfg > 64) ? 64 : max_len_cfg;
      small_top = (top >= afs_pkg::HdrBytes && top < 24) ? top : 24;
      if (pick < 8) begin
        send_frame($urandom_range(0, afs_pkg::HdrBytes - 1), afs_pkg::HdrBytes,
                   afs_pkg::HdrBytes);
      end else if (pick < 15 && max_len_cfg < 13'h1FFF) begin
        send_frame($urandom_range(max_len_cfg + 1, 8191), afs_pkg::HdrBytes,
                   afs_pkg::HdrBytes);
      end else begin
        if (top > 24 && $urandom_range(0, 6) == 0) len = $urandom_range(25, top);
        else len = $urandom_range(afs_pkg::HdrBytes, small_top);
        if ($urandom_range(0, 9) == 0) eos_at = $urandom_range(0, len - 1);
        else if ($urandom_range(0, 9) == 0) eos_at = len - 1;
        else eos_at = len;
        send_frame(len, len, eos_at);
      end
    end
  endtask

  // A stray sync byte ahead of a header is rejected and slid out of the window, then a
  // frame that is exactly one header long is passed through and ends on its sixth byte.
  task automatic test_hunt_six_byte_frame();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF1, 1'b0);
    send_byte(8'h50, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC0, 1'b0);
  endtask

  // A header whose length is five bytes is treated as noise; the stream ends on it.
  task automatic test_short_length();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF9, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA0, 1'b1);
  endtask

  // The longest length the field can hold is above the reset limit and is rejected.
  task automatic test_long_length();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF1, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // An eight-byte frame with the lowest nonzero table rate and all channel bits set is
  // cut by end of stream on its seventh byte.
  task automatic test_truncation();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAB, 1'b1);
  endtask

  task automatic test_random_default();
    random_stream(40);
  endtask

  // The receiver stops for a long stretch while frames keep coming, so the entry queue
  // fills and the input side has to stall.
  task automatic test_backpressure();
    wait_idle();
    tx_gaps_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (2) send_frame(20, 20, 20);
    tx_gaps_on = 1'b1;
  endtask

  // With a limit of one byte no header can ever be accepted.
  task automatic test_max_len_one();
    write_max_len(13'd1);
    random_stream(20);
    send_frame(afs_pkg::HdrBytes, afs_pkg::HdrBytes, afs_pkg::HdrBytes - 1);
  endtask

  // The largest limit accepts a header of the largest length, sent without gaps; the
  // stream ends forty bytes into that frame.
  task automatic test_max_len_full();
    write_max_len(13'h1FFF);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_frame(8191, 40, 39);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    random_stream(20);
  endtask

  task automatic test_random_mid();
    write_max_len(13'($urandom_range(afs_pkg::HdrBytes, 64)));
    random_stream(30);
  endtask

  // Back to the reset limit, and the tail of the run goes without any idling.
  task automatic test_idle_free_tail();
    write_max_len(afs_pkg::MAX_LEN_RESET);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    random_stream(30);
  endtask

  // Receiver: random stall bursts, plus the long hold when a test asks for one.
  always @(posedge clk_i) begin
    if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      m_axis_tready <= 1'b0;
      rx_hold_cnt   <= LONG_HOLD;
    end else if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cnt   <= $urandom_range(0, 15);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic cmp_field(input string name, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Every accepted output request is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    adts_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats_q.size() == 0) begin
        $error("result with no expectation waiting: out_byte %0d", m_axis_tdata[7:0]);
        mismatch_cnt++;
      end else begin
        want = pending_beats_q.pop_front();
        cmp_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
        cmp_field("rate_index", want.rate_index, m_axis_tdata[11:8]);
        cmp_field("sample_rate_hz", want.sample_rate_hz, m_axis_tdata[28:12]);
        cmp_field("channel_config", want.channel_config, m_axis_tdata[31:29]);
        cmp_field("length_of_frame", want.length_of_frame, m_axis_tdata[44:32]);
        cmp_field("frame_start", want.frame_start, m_axis_tuser[0]);
        cmp_field("truncated", want.truncated, m_axis_tuser[1]);
        cmp_field("last_result", want.last_result, m_axis_tuser[2]);
        cmp_field("frame_end", want.frame_end, m_axis_tlast);
        beats_checked++;
        if (want.frame_start) frames_seen++;
        if (want.truncated) trunc_seen++;
      end
    end
  end

  initial begin
    clear_sync_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hunt_six_byte_frame();
    test_short_length();
    test_long_length();
    test_truncation();
    test_random_default();
    test_backpressure();
    test_max_len_one();
    test_max_len_full();
    test_random_mid();
    test_idle_free_tail();

    // All stimulus is in; let the last results drain before the verdict.
    wait_idle();
    $display("Checked %0d result bytes in %0d frames (%0d cut by end of stream).",
             beats_checked, frames_seen, trunc_seen);
    $display("Sent %0d frame bytes over limits 1, 8191, mid-range and reset value.",
             frame_bytes_sent);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
